// ===== src/fcer_pkg.sv =====
package fcer_pkg;

    localparam int MAX_TAPS    = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;

    // Field widths fixed by the interface.
    localparam int KLEN_W = 4;
    localparam int TIDX_W = 4;

    // Request codes carried by req_type.
    localparam logic REQ_LOAD_TAP = 1'b0;
    localparam logic REQ_SAMPLE   = 1'b1;

    // Frame sample counter saturates at this value.
    localparam int SEEN_W   = 4;
    localparam int SEEN_MAX = 15;

    localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int LEFT_W = $clog2(((MAX_TAPS > SEEN_MAX) ? MAX_TAPS : SEEN_MAX) + 1);
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1);
    localparam int SHR_W  = ACC_W - FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [SHR_W-1:0]       t_shr;

    // Kernel length actually used: forced odd and limited to the tap store.
    function automatic logic [CNT_W-1:0] eff_len(input logic [KLEN_W-1:0] kl);
        int k;
        k = int'(kl) | 1;
        if (k > MAX_TAPS) begin
            k = MAX_TAPS;
            if ((k % 2) == 0) begin
                k = k - 1;
            end
        end
        return CNT_W'(k);
    endfunction

    // Floor shift back to Q1.15 and clamp to the sample range.
    function automatic t_sample round_sat(input t_acc acc);
        t_shr    s;
        t_shr    hi;
        t_shr    lo;
        t_sample y;
        s  = t_shr'(acc >>> FRAC_BITS);
        hi = t_shr'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - t_shr'(1);
        if (s > hi) begin
            y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (s < lo) begin
            y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y = t_sample'(s);
        end
        return y;
    endfunction

endpackage

// ===== src/fir_convolution_edge_replicate_top.sv =====
// A tap load word is taken in the idle state; the block stays idle and ready for the next word.
// A sample word with a full window of K taps passes through the single shared
// multiply-accumulate unit, one tap per cycle, then a rounding and saturation step.
// Words leave after the MAC, rounding and emit states, one per cycle unless stalled.
// A sample word that produces no result leaves the block idle and ready.
// Synchronous active-low reset clears taps, window, counters and sets kernel length to 1.
module fir_convolution_edge_replicate_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fcer_pkg::KLEN_W-1:0]   i_cfg_kernel_length,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [fcer_pkg::TIDX_W-1:0]   i_tap_index,
    input  logic signed [fcer_pkg::SAMPLE_BITS-1:0] i_item_value,
    input  logic                          i_frame_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [fcer_pkg::SAMPLE_BITS-1:0] o_filtered_value,
    output logic                          o_final_output
);
    import fcer_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_RND  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state;
    logic [KLEN_W-1:0] r_klen;
    t_sample           r_taps   [MAX_TAPS];
    t_sample           r_window [MAX_TAPS];
    logic [SEEN_W-1:0] r_seen;
    logic [CNT_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_m;
    t_acc              r_acc;
    t_sample           r_y;
    logic [LEFT_W-1:0] r_left;
    logic              r_last;
    logic              r_out_valid;
    t_sample           r_out_value;
    logic              r_out_final;

    logic              in_fire;
    logic              out_free;
    logic              emit_fire;
    logic [CNT_W-1:0]  k_now;
    logic [CNT_W-1:0]  half;
    logic [SEEN_W-1:0] n_seen;
    logic [LEFT_W-1:0] n_left;
    t_prod             prod;

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = (r_state == ST_IDLE);
    assign in_fire          = i_in_valid && o_in_ready;
    assign out_free         = !r_out_valid || i_out_ready;
    assign emit_fire        = (r_state == ST_EMIT) && out_free;
    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_final_output   = r_out_final;

    assign k_now  = eff_len(r_klen);
    assign half   = (k_now - CNT_W'(1)) >> 1;
    assign n_seen = (r_seen < SEEN_W'(SEEN_MAX)) ? r_seen + SEEN_W'(1) : r_seen;
    assign n_left = ((r_seen < k_now) ? LEFT_W'(half) : LEFT_W'(0)) + LEFT_W'(1)
                  + (i_frame_end ? LEFT_W'(half) : LEFT_W'(0));
    assign prod   = r_window[r_m] * r_taps[r_m];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_klen      <= KLEN_W'(1);
            r_seen      <= '0;
            r_k         <= '0;
            r_m         <= '0;
            r_left      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_taps[i]   <= '0;
                r_window[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_klen <= i_cfg_kernel_length;
            end

            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire && (i_req_type == REQ_LOAD_TAP)) begin
                        if (i_tap_index < MAX_TAPS) begin
                            r_taps[IDX_W'(i_tap_index)] <= i_item_value;
                        end
                    end else if (in_fire) begin
                        for (int i = MAX_TAPS - 1; i > 0; i--) begin
                            r_window[i] <= r_window[i-1];
                        end
                        r_window[0] <= i_item_value;
                        r_seen      <= i_frame_end ? '0 : n_seen;
                        r_last      <= i_frame_end;
                        r_k         <= k_now;
                        r_m         <= '0;
                        r_acc       <= '0;
                        if (n_seen >= k_now) begin
                            r_left  <= n_left;
                            r_state <= ST_MAC;
                        end else if (i_frame_end) begin
                            // Short frame: one zero word per sample seen.
                            r_y     <= '0;
                            r_left  <= LEFT_W'(n_seen);
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_MAC: begin
                    r_acc <= r_acc + t_acc'(prod);
                    r_m   <= r_m + IDX_W'(1);
                    if (CNT_W'(r_m) == r_k - CNT_W'(1)) begin
                        r_state <= ST_RND;
                    end
                end
                ST_RND: begin
                    r_y     <= round_sat(r_acc);
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Front pads, the result itself and back pads all carry the same value.
                    if (out_free) begin
                        r_out_value <= r_y;
                        r_out_final <= r_last && (r_left == LEFT_W'(1));
                        r_left      <= r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_mac_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (CNT_W'(r_m) < r_k))
        else $error("tap index ran past the kernel length");

    a_emit_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("emit phase entered with no words left");

    a_round_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND) |=> (r_state == ST_EMIT))
        else $error("rounding step not followed by emit phase");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_value)))
        else $error("stalled output word changed");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");

endmodule
